@@ hw/rtl/srr_pkg.sv @@
// Shared types and constants for the selective-repeat receiver.
package srr_pkg;

  localparam int unsigned SEQ_W     = 5;
  localparam int unsigned PAYLOAD_W = 32;

  // Packet kind carried in the input tuser
  localparam logic PK_DATA = 1'b0;
  localparam logic PK_ACK  = 1'b1;

  typedef enum logic [1:0] {
    RK_ACK_SEND = 2'd0,
    RK_DELIVER  = 2'd1,
    RK_ACK_NEW  = 2'd2,
    RK_ACK_DUP  = 2'd3
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                 ok;
    logic                 kind;
    logic [SEQ_W-1:0]     seq;
    logic [SEQ_W-1:0]     ack;
    logic [PAYLOAD_W-1:0] payload;
  } pkt_t;

  // One result issued by the sequencer; delivered payload comes from the RAM
  typedef struct packed {
    logic             valid;
    result_kind_e     kind;
    logic [SEQ_W-1:0] ack_seq;
    logic [SEQ_W-1:0] deliver_seq;
    logic             last;
  } res_t;

endpackage

@@ hw/rtl/selective_repeat_receiver.sv @@
// Selective-repeat ARQ receiver top level: sequencer, payload RAM, output register.
// Each input transaction is one received packet. Packets with a clear checksum flag or a
// slot number not below SLOTS give no result. A data packet for a fresh slot is stored
// and acknowledged; then, if the next undelivered slot is now held, the contiguous run
// of stored payloads from it is released in order (one result each, tlast on the final
// one). A repeated data packet is acknowledged again; an ack packet reports a new or
// duplicate ack. Slots are used once, no wrap. Timing: the block takes a packet, decides
// in the EVAL state once the output register is free, then returns to idle; it takes no
// new packet before it is through with the last. A packet that starts a drain first goes
// through a read state of the registered payload RAM, then one payload per cycle leaves
// its single read port while tready is high; back-pressure stalls the sequencer in place.
module selective_repeat_receiver #(
  parameter int unsigned SLOTS        = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // seq_number[4:0], ack_number[9:5], payload[41:10]
  input  logic [1:0]  s_axis_tuser_i,  // checksum_ok[0], packet_kind[1]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // ack_seq[4:0], deliver_seq[9:5], deliver_payload[41:10]
  output logic [1:0]  m_axis_tuser_o,  // result_kind[1:0]
  output logic        m_axis_tlast_o
);
  import srr_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);

  pkt_t                    pkt;
  res_t                    res;
  logic                    out_free;
  logic                    ram_wr_en;
  logic [IDX_W-1:0]        ram_wr_addr, ram_rd_addr;
  logic [PAYLOAD_BITS-1:0] ram_wr_data, ram_rd_data;
  logic [PAYLOAD_W-1:0]    dpay;

  // Output register state
  logic                 m_valid_q, m_valid_d;
  logic [47:0]          m_data_q;
  logic [1:0]           m_user_q;
  logic                 m_last_q;

  // Unpack the incoming transaction
  assign pkt.ok      = s_axis_tuser_i[0];
  assign pkt.kind    = s_axis_tuser_i[1];
  assign pkt.seq     = s_axis_tdata_i[4:0];
  assign pkt.ack     = s_axis_tdata_i[9:5];
  assign pkt.payload = s_axis_tdata_i[41:10];

  // Output register can take a new result when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;

  srr_ctrl #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .pkt_i         (pkt),
    .out_free_i    (out_free),
    .res_o         (res),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_addr_o (ram_rd_addr)
  );

  // Payload store, one word per slot
  srr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Stored width may differ from the port field; zero-extend or truncate
  assign dpay = (res.kind == RK_DELIVER) ? PAYLOAD_W'(ram_rd_data) : '0;

  assign m_valid_d = res.valid || (m_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      m_data_q <= {6'b0, dpay, res.deliver_seq, res.ack_seq};
      m_user_q <= res.kind;
      m_last_q <= res.last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // Sequencer only issues a result into a free output register
  a_issue_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result issued into occupied output register");

  // No result is issued while the block is taking packets
  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !s_axis_tready_o)
    else $error("result issued while idle");

  // An accepted packet keeps the block busy for its evaluation cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready right after accepting a packet");

endmodule

@@ hw/rtl/srr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/srr_ctrl.sv @@
// Sequencer: packet decode, slot flags, in-order drain pointer.
module srr_ctrl #(
  parameter int unsigned SLOTS        = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  srr_pkg::pkt_t            pkt_i,
  input  logic                     out_free_i,
  output srr_pkg::res_t            res_o,
  output logic                     ram_wr_en_o,
  output logic [$clog2(SLOTS)-1:0] ram_wr_addr_o,
  output logic [PAYLOAD_BITS-1:0]  ram_wr_data_o,
  output logic [$clog2(SLOTS)-1:0] ram_rd_addr_o
);
  import srr_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  state_e           state_q, state_d;
  pkt_t             pkt_q;
  logic [CNT_W-1:0] ntd_q, ntd_d;     // next slot to deliver
  logic [CNT_W-1:0] ntd_inc;
  logic [SLOTS-1:0] recv_q, recv_d;
  logic [SLOTS-1:0] acked_q, acked_d;

  logic [IDX_W-1:0] seq_idx, ack_idx, ntd_idx, nxt_idx;
  logic             in_range, drain_go, more;

  assign seq_idx = IDX_W'(pkt_q.seq);
  assign ack_idx = IDX_W'(pkt_q.ack);
  assign ntd_idx = IDX_W'(ntd_q);
  assign ntd_inc = ntd_q + CNT_W'(1);
  assign nxt_idx = IDX_W'(ntd_inc);

  assign in_range = (pkt_q.kind == PK_DATA) ? (int'(pkt_q.seq) < SLOTS)
                                            : (int'(pkt_q.ack) < SLOTS);
  // Drain starts if the head slot is already held or is the one just written
  assign drain_go = (int'(ntd_q) < SLOTS) && (recv_q[ntd_idx] || (ntd_idx == seq_idx));
  assign more     = (int'(ntd_inc) < SLOTS) && recv_q[nxt_idx];

  assign ram_wr_addr_o = seq_idx;
  assign ram_wr_data_o = PAYLOAD_BITS'(pkt_q.payload);

  always_comb begin
    state_d       = state_q;
    ntd_d         = ntd_q;
    recv_d        = recv_q;
    acked_d       = acked_q;
    res_o         = '0;
    ram_wr_en_o   = 1'b0;
    ram_rd_addr_o = ntd_idx;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!pkt_q.ok || !in_range) begin
          state_d = ST_IDLE;
        end else if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.last  = 1'b1;
          state_d     = ST_IDLE;
          if (pkt_q.kind == PK_DATA) begin
            res_o.kind    = RK_ACK_SEND;
            res_o.ack_seq = pkt_q.seq;
            if (!recv_q[seq_idx]) begin
              recv_d[seq_idx] = 1'b1;
              ram_wr_en_o     = 1'b1;
              if (drain_go) begin
                res_o.last = 1'b0;
                state_d    = ST_RD;
              end
            end
          end else begin
            res_o.kind       = acked_q[ack_idx] ? RK_ACK_DUP : RK_ACK_NEW;
            res_o.ack_seq    = pkt_q.ack;
            acked_d[ack_idx] = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          res_o.valid       = 1'b1;
          res_o.kind        = RK_DELIVER;
          res_o.deliver_seq = SEQ_W'(ntd_q);
          res_o.last        = !more;
          ntd_d             = ntd_inc;
          if (more) begin
            ram_rd_addr_o = nxt_idx;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ntd_q   <= '0;
      recv_q  <= '0;
      acked_q <= '0;
    end else begin
      state_q <= state_d;
      ntd_q   <= ntd_d;
      recv_q  <= recv_d;
      acked_q <= acked_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pkt_q <= pkt_i;
    end
  end

endmodule
